// ----- rtl/core/tsfr_pkg.sv -----
// Shared types and constants for the timestamp sync frame receiver.
// No dependencies; imported by tsfr_core and timestamp_sync_frame_receiver.
`timescale 1ns / 1ps

package tsfr_pkg;

    // Frame header bytes.
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;

    // Register reset values.
    localparam logic [7:0]  LOST_LIMIT_RST     = 8'd5;
    localparam logic [7:0]  CONVERGE_START_RST = 8'd12;
    localparam logic [15:0] TIMER_BASE_RST     = 16'd31231;
    localparam logic [15:0] TIMER_COMPARE_RST  = 16'd31233;

    // Lost-seconds count after reset, and its saturation point.
    localparam logic [7:0] LOST_SECONDS_RST = 8'd254;
    localparam logic [7:0] LOST_SECONDS_MAX = 8'd255;

    // Register indexes on the configuration port (word address bits).
    localparam logic [1:0] REG_LOST_LIMIT     = 2'd0;
    localparam logic [1:0] REG_CONVERGE_START = 2'd1;
    localparam logic [1:0] REG_TIMER_BASE     = 2'd2;
    localparam logic [1:0] REG_TIMER_COMPARE  = 2'd3;

    // Widths of the stream payloads.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]  lost_limit;
        logic [7:0]  converge_start;
        logic [15:0] timer_base;
        logic [15:0] timer_compare;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  rx_byte;
        logic [15:0] timer_count;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic        frame_done;
        logic        stamp_valid;
        logic [31:0] stamp_value;
        logic        load_timer;
        logic [15:0] load_value;
        logic        write_compare;
        logic        synchronized;
    } out_item_t;

endpackage

// ----- rtl/core/tsfr_core.sv -----
// Frame parser and convergence tracker: holds the receiver state and forms
// one result from one item. Depends on tsfr_pkg.
`timescale 1ns / 1ps

module tsfr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  tsfr_pkg::in_item_t item,
    input  tsfr_pkg::cfg_t    cfg,
    output tsfr_pkg::out_item_t res
);
    import tsfr_pkg::*;

    // Parser phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HDR2  = 3'd1;
    localparam logic [2:0] PH_BYTE0 = 3'd2;
    localparam logic [2:0] PH_BYTE1 = 3'd3;
    localparam logic [2:0] PH_BYTE2 = 3'd4;
    localparam logic [2:0] PH_BYTE3 = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] last_reg, last_next;
    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  lost_reg, lost_next;

    logic [31:0] stamp;
    logic        frame_end;
    logic        consecutive;
    logic        restart;
    logic [7:0]  offset_dec;

    // Stamp as it stands once the last byte is merged in.
    assign stamp       = {item.rx_byte, asm_reg[23:0]};
    assign consecutive = ((last_reg + 32'd1) == stamp);
    assign restart     = (lost_reg >= cfg.lost_limit);
    assign offset_dec  = (offset_reg >= 8'd2) ? (offset_reg - 8'd2) : 8'd0;

    // Next state and result for the item at hand.
    always_comb
    begin
        phase_next  = phase_reg;
        asm_next    = asm_reg;
        last_next   = last_reg;
        offset_next = offset_reg;
        lost_next   = lost_reg;
        frame_end   = 1'b0;
        res         = '0;

        if (item.cmd == CMD_TICK)
        begin
            if (lost_reg != LOST_SECONDS_MAX)
            begin
                lost_next = lost_reg + 8'd1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    phase_next = (item.rx_byte == HDR_SECOND) ? PH_BYTE0 : PH_IDLE;
                end
                PH_BYTE0:
                begin
                    asm_next[7:0] = item.rx_byte;
                    phase_next    = PH_BYTE1;
                end
                PH_BYTE1:
                begin
                    asm_next[15:8] = item.rx_byte;
                    phase_next     = PH_BYTE2;
                end
                PH_BYTE2:
                begin
                    asm_next[23:16] = item.rx_byte;
                    phase_next      = PH_BYTE3;
                end
                PH_BYTE3:
                begin
                    asm_next   = stamp;
                    phase_next = PH_IDLE;
                    frame_end  = 1'b1;
                end
                default:
                begin
                    phase_next = (item.rx_byte == HDR_FIRST) ? PH_HDR2 : PH_IDLE;
                end
            endcase
        end

        // A completed frame: check continuity and steer the timer.
        if (frame_end)
        begin
            res.frame_done  = 1'b1;
            res.stamp_value = stamp;
            last_next       = stamp;
            if (consecutive)
            begin
                lost_next = '0;
                if (restart)
                begin
                    offset_next       = cfg.converge_start;
                    res.load_timer    = 1'b1;
                    res.write_compare = 1'b1;
                end
                else
                begin
                    offset_next    = offset_dec;
                    res.load_timer = (item.timer_count < cfg.timer_compare);
                end
                if (res.load_timer)
                begin
                    res.load_value = cfg.timer_base - {8'd0, offset_next};
                end
                res.stamp_valid  = 1'b1;
                res.synchronized = (offset_next == 8'd0);
            end
        end
    end

    // State update, once per consumed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            asm_reg    <= '0;
            last_reg   <= '0;
            offset_reg <= '0;
            lost_reg   <= LOST_SECONDS_RST;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            asm_reg    <= asm_next;
            last_reg   <= last_next;
            offset_reg <= offset_next;
            lost_reg   <= lost_next;
        end
    end

    // A restart always clears the lost-seconds count.
    a_restart_clears_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.write_compare) |=> (lost_reg == 8'd0))
        else $error("lost-seconds count not cleared after restart");

    // Every completed frame becomes the reference for the next one.
    a_last_stamp_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.frame_done) |=> (last_reg == $past(res.stamp_value)))
        else $error("previous stamp not updated on frame end");

    // A tick below saturation adds exactly one lost second.
    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.cmd == CMD_TICK && lost_reg != LOST_SECONDS_MAX)
        |=> (lost_reg == $past(lost_reg) + 8'd1))
        else $error("tick did not count a lost second");

    // A tick never disturbs the parser.
    a_tick_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.cmd == CMD_TICK) |=> $stable(phase_reg))
        else $error("tick changed the parser phase");

endmodule

// ----- rtl/core/timestamp_sync_frame_receiver.sv -----
// Top level of the timestamp sync frame receiver: stream ports, input and
// result registers, configuration registers. Depends on tsfr_pkg, tsfr_core.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one item per transaction: s_tuser is the command
// (0 = received serial byte, 1 = one-second tick), s_tdata holds the byte and
// the current timer count. A frame is 0xAA, 0xAF and four timestamp bytes,
// least significant first. Every input transaction yields exactly one result
// transaction on the master stream; most results are all zero, and the one
// for the last frame byte carries the stamp and the timer steering flags.
// The parser works on the item in the input register, and the result register
// takes its result when the item advances.
// Throughput is one item per cycle while the master side takes results. When
// the master side stalls, the result register holds, the input register fills,
// and s_tready drops once the input register is full; nothing is lost.
// Reset (rst_n, asynchronous, active low) empties both registers, returns
// the parser to header search, clears both stamps and the convergence offset,
// sets the lost-seconds count to 254 and loads the register reset values.
// The user must write registers over the APB port only while the stream is
// idle; the block itself does not enforce this.

module timestamp_sync_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    // Slave stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsfr_pkg::IN_DATA_W-1:0]  s_tdata,  // rx_byte, timer_count
    input  logic                            s_tuser,  // cmd
    // Master stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame_done, stamp_valid, stamp_value, load_timer, load_value,
    // write_compare, synchronized, zero fill
    output logic [tsfr_pkg::OUT_DATA_W-1:0] m_tdata,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tsfr_pkg::*;

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t res;
    logic      advance;
    logic      cfg_write;

    // The input register moves on when the result register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.cmd         <= s_tuser;
            in_item_reg.rx_byte     <= s_tdata[7:0];
            in_item_reg.timer_count <= s_tdata[23:8];
        end
    end

    tsfr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_item_reg.synchronized,
                       out_item_reg.write_compare,
                       out_item_reg.load_value,
                       out_item_reg.load_timer,
                       out_item_reg.stamp_value,
                       out_item_reg.stamp_valid,
                       out_item_reg.frame_done};

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lost_limit     <= LOST_LIMIT_RST;
            cfg_reg.converge_start <= CONVERGE_START_RST;
            cfg_reg.timer_base     <= TIMER_BASE_RST;
            cfg_reg.timer_compare  <= TIMER_COMPARE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_LOST_LIMIT:     cfg_reg.lost_limit     <= pwdata[7:0];
                REG_CONVERGE_START: cfg_reg.converge_start <= pwdata[7:0];
                REG_TIMER_BASE:     cfg_reg.timer_base     <= pwdata[15:0];
                REG_TIMER_COMPARE:  cfg_reg.timer_compare  <= pwdata[15:0];
                default:            cfg_reg.lost_limit     <= cfg_reg.lost_limit;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            REG_LOST_LIMIT:     prdata = {24'd0, cfg_reg.lost_limit};
            REG_CONVERGE_START: prdata = {24'd0, cfg_reg.converge_start};
            REG_TIMER_BASE:     prdata = {16'd0, cfg_reg.timer_base};
            REG_TIMER_COMPARE:  prdata = {16'd0, cfg_reg.timer_compare};
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- bench/timestamp_sync_frame_receiver_test.sv -----
// Self-checking bench for the timestamp sync frame receiver: sync frames, headers and ticks
// go in as stream transactions, every result transaction is checked against a behavioral copy.
// Depends on tsfr_pkg and timestamp_sync_frame_receiver.
`timescale 1ns / 1ps

module timestamp_sync_frame_receiver_test;

    import tsfr_pkg::*;

    // Parser position while following the sync stream.
    typedef enum logic [2:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        TAKE_B0,
        TAKE_B1,
        TAKE_B2,
        TAKE_B3
    } sync_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;     // rx_byte, timer_count
    logic                  s_tuser = 1'b0;   // cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // frame_done, stamp_valid, stamp_value, load_timer, load_value,
    // write_compare, synchronized, zero fill
    logic [OUT_DATA_W-1:0] m_tdata;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copy and receiver state as the bench sees them.
    cfg_t        cfg = '{LOST_LIMIT_RST, CONVERGE_START_RST, TIMER_BASE_RST, TIMER_COMPARE_RST};
    sync_phase_t parse_at = SEEK_FIRST;
    logic [31:0] stamp_accum = '0;
    logic [31:0] prev_stamp = '0;
    logic [7:0]  conv_offset = '0;
    logic [7:0]  lost_count = LOST_SECONDS_RST;

    out_item_t sync_outcomes[$];

    bit steady = 1'b0;           // no idling on either side while set
    bit ticks_in_frames = 1'b0;  // scatter ticks between frame bytes

    int items_sent = 0;
    int results_seen = 0;
    int frames_seen = 0;
    int stamps_taken = 0;
    int restarts_seen = 0;
    int settings_applied = 0;
    int fail_count = 0;

    timestamp_sync_frame_receiver u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // Result side stalls about a third of the time unless the steady stretch is on.
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 33);
    end

    // Advance the receiver state by one stream item and return the result it causes.
    function automatic out_item_t track_sync_stream(input in_item_t it);
        out_item_t r;
        r = '0;
        if (it.cmd == CMD_TICK)
        begin
            if (lost_count != LOST_SECONDS_MAX)
                lost_count++;
            return r;
        end
        case (parse_at)
            SEEK_SECOND:
                parse_at = (it.rx_byte == HDR_SECOND) ? TAKE_B0 : SEEK_FIRST;
            TAKE_B0:
            begin
                stamp_accum[7:0] = it.rx_byte;
                parse_at = TAKE_B1;
            end
            TAKE_B1:
            begin
                stamp_accum[15:8] = it.rx_byte;
                parse_at = TAKE_B2;
            end
            TAKE_B2:
            begin
                stamp_accum[23:16] = it.rx_byte;
                parse_at = TAKE_B3;
            end
            TAKE_B3:
            begin
                stamp_accum[31:24] = it.rx_byte;
                parse_at = SEEK_FIRST;
                r.frame_done = 1'b1;
                r.stamp_value = stamp_accum;
                // Only a stamp that follows the previous one by a second is taken.
                if (prev_stamp + 32'd1 == stamp_accum)
                begin
                    if (lost_count >= cfg.lost_limit)
                    begin
                        conv_offset = cfg.converge_start;
                        r.load_timer = 1'b1;
                        r.load_value = cfg.timer_base - {8'd0, conv_offset};
                        r.write_compare = 1'b1;
                    end
                    else
                    begin
                        conv_offset = (conv_offset >= 8'd2) ? conv_offset - 8'd2 : 8'd0;
                        if (it.timer_count < cfg.timer_compare)
                        begin
                            r.load_timer = 1'b1;
                            r.load_value = cfg.timer_base - {8'd0, conv_offset};
                        end
                    end
                    lost_count = '0;
                    r.stamp_valid = 1'b1;
                    r.synchronized = (conv_offset == 8'd0);
                end
                prev_stamp = stamp_accum;
            end
            default:
                parse_at = (it.rx_byte == HDR_FIRST) ? SEEK_SECOND : SEEK_FIRST;
        endcase
        return r;
    endfunction

    function automatic string show_result(input out_item_t r);
        return $sformatf("fd=%0d sv=%0d stamp=%h lt=%0d lv=%h wc=%0d sync=%0d",
                         r.frame_done, r.stamp_valid, r.stamp_value, r.load_timer,
                         r.load_value, r.write_compare, r.synchronized);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    // Timer counts: a quarter of them sit within one of the compare value.
    function automatic logic [15:0] pick_count();
        logic [15:0] c;
        if ($urandom_range(3) == 0)
            c = cfg.timer_compare + 16'($urandom_range(2)) - 16'd1;
        else
            c = 16'($urandom_range(65535));
        return c;
    endfunction

    // Compare each result transaction with the oldest prediction.
    task automatic check_result();
        out_item_t got;
        out_item_t want;
        got.frame_done    = m_tdata[0];
        got.stamp_valid   = m_tdata[1];
        got.stamp_value   = m_tdata[33:2];
        got.load_timer    = m_tdata[34];
        got.load_value    = m_tdata[50:35];
        got.write_compare = m_tdata[51];
        got.synchronized  = m_tdata[52];
        results_seen++;
        if (sync_outcomes.size() == 0)
        begin
            note_failure($sformatf("result %0d with no transaction outstanding: %s",
                                   results_seen, show_result(got)));
        end
        else
        begin
            want = sync_outcomes.pop_front();
            frames_seen   += want.frame_done;
            stamps_taken  += want.stamp_valid;
            restarts_seen += want.write_compare;
            if (got !== want)
                note_failure($sformatf("result %0d expected %s, got %s",
                                       results_seen, show_result(want), show_result(got)));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    // Send one stream transaction after a random gap, none while steady, and record its prediction.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        if (!steady)
        begin
            while ($urandom_range(99) < 33)
                gap++;
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.timer_count, it.rx_byte};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sync_outcomes.push_back(track_sync_stream(it));
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [15:0] count);
        in_item_t it;
        it.cmd = CMD_BYTE;
        it.rx_byte = b;
        it.timer_count = count;
        send_item(it);
    endtask

    // The byte field of a tick is don't-care, so it carries random data.
    task automatic send_tick();
        in_item_t it;
        it.cmd = CMD_TICK;
        it.rx_byte = 8'($urandom_range(255));
        it.timer_count = 16'($urandom_range(65535));
        send_item(it);
    endtask

    // Header, then the stamp least significant byte first; the last byte carries final_count.
    task automatic send_frame(input logic [31:0] stamp, input logic [15:0] final_count);
        send_byte(HDR_FIRST, pick_count());
        send_byte(HDR_SECOND, pick_count());
        for (int k = 0; k < 4; k++)
        begin
            if (ticks_in_frames && $urandom_range(19) == 0)
                send_tick();
            send_byte(stamp[8*k +: 8], (k == 3) ? final_count : pick_count());
        end
    endtask

    // Stop the stream and let every outstanding result come back.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (sync_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB read of one register; psel stays high so transfers can run back to back.
    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            note_failure($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    endtask

    // APB write of one register followed by a read back.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_LOST_LIMIT:     cfg.lost_limit = val[7:0];
            REG_CONVERGE_START: cfg.converge_start = val[7:0];
            REG_TIMER_BASE:     cfg.timer_base = val[15:0];
            default:            cfg.timer_compare = val[15:0];
        endcase
        check_reg(idx, val);
    endtask

    task automatic release_bus();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] limit, input logic [7:0] start,
                                  input logic [15:0] base, input logic [15:0] compare);
        write_reg(REG_LOST_LIMIT, {24'd0, limit});
        write_reg(REG_CONVERGE_START, {24'd0, start});
        write_reg(REG_TIMER_BASE, {16'd0, base});
        write_reg(REG_TIMER_COMPARE, {16'd0, compare});
        release_bus();
        settings_applied++;
    endtask

    task automatic test_register_defaults();
        check_reg(REG_LOST_LIMIT, {24'd0, LOST_LIMIT_RST});
        check_reg(REG_CONVERGE_START, {24'd0, CONVERGE_START_RST});
        check_reg(REG_TIMER_BASE, {16'd0, TIMER_BASE_RST});
        check_reg(REG_TIMER_COMPARE, {16'd0, TIMER_COMPARE_RST});
        release_bus();
    endtask

    // Wrong second header, a stray byte, and a repeated first header byte.
    task automatic test_header_errors();
        send_byte(HDR_FIRST, 16'h0000);
        send_byte(8'h00, 16'hFFFF);
        send_byte(8'h55, pick_count());
        send_byte(HDR_FIRST, pick_count());
        send_byte(HDR_FIRST, pick_count());
        send_byte(HDR_SECOND, pick_count());
    endtask

    // Lost count saturates, first stamp restarts convergence, next one steps it down.
    task automatic test_restart_and_step();
        send_tick();
        send_tick();
        send_frame(32'h0000_0001, pick_count());
        send_frame(32'h0000_0002, 16'h0000);
    endtask

    // A rejected all-ones stamp still becomes the reference, so zero is consecutive.
    task automatic test_stamp_wrap();
        send_frame(32'hFFFF_FFFF, pick_count());
        send_frame(32'h0000_0000, 16'hFFFF);
        drain_stream();
    endtask

    // Mostly consecutive frames, with tick bursts, bad stamps, bad headers and noise.
    task automatic run_mixed_traffic(input int item_goal);
        int first;
        int pick;
        logic [7:0] junk;
        first = items_sent;
        while (items_sent - first < item_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_frame(prev_stamp + 32'd1, pick_count());
            else if (pick < 70)
                send_frame($urandom(), pick_count());
            else if (pick < 85)
                repeat ($urandom_range(1, 8)) send_tick();
            else if (pick < 93)
            begin
                junk = 8'($urandom_range(255));
                if (junk == HDR_SECOND)
                    junk = ~junk;
                send_byte(HDR_FIRST, pick_count());
                send_byte(junk, pick_count());
            end
            else
                send_byte(8'($urandom_range(255)), pick_count());
        end
        drain_stream();
    endtask

    // Defaults, one extreme, the other, a middle set, then random register settings.
    task automatic test_mixed_traffic();
        ticks_in_frames = 1'b1;
        run_mixed_traffic(190);
        apply_settings(8'd0, 8'd254, 16'd0, 16'd0);
        run_mixed_traffic(190);
        steady = 1'b1;
        apply_settings(8'd255, 8'd1, 16'hFFFF, 16'hFFFF);
        run_mixed_traffic(190);
        steady = 1'b0;
        apply_settings(8'd3, 8'd7, 16'd4, 16'd40000);
        run_mixed_traffic(190);
        apply_settings(8'($urandom_range(255)), 8'($urandom_range(254)),
                       16'($urandom_range(65535)), 16'($urandom_range(65535)));
        run_mixed_traffic(190);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_defaults();
        test_header_errors();
        test_restart_and_step();
        test_stamp_wrap();
        test_mixed_traffic();
        while (sync_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Covered %0d stream transactions, %0d frames, %0d stamps taken, %0d restarts",
                 items_sent, frames_seen, stamps_taken, restarts_seen);
        $display("over %0d register settings; %0d failures.", settings_applied, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop if the stream hangs.
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", sync_outcomes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tsfr_pkg.sv
rtl/core/tsfr_core.sv
rtl/core/timestamp_sync_frame_receiver.sv
bench/timestamp_sync_frame_receiver_test.sv
